@@ rtl/core/wsd_pkg.sv @@
// Shared types and constants for the websocket frame deframer.
// Holds the queue item layout, opcode codes and length codes.
// No dependencies.
`default_nettype none
package wsd_pkg;

  localparam logic [3:0] OP_TEXT   = 4'd1;
  localparam logic [3:0] OP_BIN    = 4'd2;
  localparam logic [3:0] OP_CLS    = 4'd8;
  localparam logic [3:0] OP_PONG   = 4'd10;

  localparam logic [6:0] LEN7_SHORT_MAX = 7'd125;
  localparam logic [6:0] LEN7_EXT16     = 7'd126;

  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [7:0] data;
    logic [7:0] key;
    logic [3:0] frame_opcode;
    logic       is_control;
    logic [3:0] message_opcode;
    logic       fin;
    logic       last;
    logic       empty;
  } wsd_item_t;

endpackage
`default_nettype wire

@@ rtl/core/wsd_front.sv @@
// Header parser: classifies each received byte and queues payload requests.
// Depends on wsd_pkg.
`default_nettype none
module wsd_front #(
  parameter int LenWidth = 64
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  input  wire  [7:0]        in_byte,
  output logic              in_ready,
  input  wire               q_ready,
  output logic              q_push,
  output wsd_pkg::wsd_item_t q_item
);
  import wsd_pkg::*;

  localparam logic [2:0] PH_HDR0 = 3'd0;
  localparam logic [2:0] PH_HDR1 = 3'd1;
  localparam logic [2:0] PH_EXT  = 3'd2;
  localparam logic [2:0] PH_MASK = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;

  logic [2:0]          phase_r, phase_nxt;
  logic [3:0]          ext_left_r, ext_left_nxt;
  logic                fin_r, fin_nxt;
  logic [3:0]          opcode_r, opcode_nxt;
  logic                masked_r, masked_nxt;
  logic [LenWidth-1:0] remain_r, remain_nxt;
  logic [1:0]          key_idx_r, key_idx_nxt;
  logic [3:0]          asm_op_r, asm_op_nxt;
  logic [7:0]          key_r [4];
  logic                accept;
  logic                len_known;
  logic                key_wr;
  logic                ctl;

  assign in_ready = q_ready;
  assign accept   = in_valid & in_ready;
  assign ctl      = (opcode_r >= OP_CLS) && (opcode_r <= OP_PONG);
  assign key_wr   = accept && (phase_r == PH_MASK);

  always_comb begin
    phase_nxt    = phase_r;
    ext_left_nxt = ext_left_r;
    fin_nxt      = fin_r;
    opcode_nxt   = opcode_r;
    masked_nxt   = masked_r;
    remain_nxt   = remain_r;
    key_idx_nxt  = key_idx_r;
    asm_op_nxt   = asm_op_r;
    len_known    = 1'b0;
    q_push       = 1'b0;
    q_item.data           = 8'd0;
    q_item.key            = 8'd0;
    q_item.frame_opcode   = opcode_r;
    q_item.is_control     = ctl;
    q_item.message_opcode = asm_op_r;
    q_item.fin            = fin_r;
    q_item.last           = 1'b1;
    q_item.empty          = 1'b1;
    if (accept) begin
      unique case (phase_r)
        PH_HDR0: begin
          fin_nxt    = in_byte[7];
          opcode_nxt = in_byte[3:0];
          if (in_byte[3:0] == OP_TEXT || in_byte[3:0] == OP_BIN) begin
            asm_op_nxt = in_byte[3:0];
          end
          phase_nxt = PH_HDR1;
        end
        PH_HDR1: begin
          masked_nxt = in_byte[7];
          if (in_byte[6:0] <= LEN7_SHORT_MAX) begin
            remain_nxt = LenWidth'(in_byte[6:0]);
            len_known  = 1'b1;
          end else begin
            remain_nxt   = '0;
            ext_left_nxt = (in_byte[6:0] == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
            phase_nxt    = PH_EXT;
          end
        end
        PH_EXT: begin
          remain_nxt   = {remain_r[LenWidth-9:0], in_byte};
          ext_left_nxt = ext_left_r - 4'd1;
          len_known    = (ext_left_r == 4'd1);
        end
        PH_MASK: begin
          key_idx_nxt = key_idx_r + 2'd1;
          if (key_idx_r == 2'd3) begin
            if (remain_r == '0) begin
              q_push    = 1'b1;
              phase_nxt = PH_HDR0;
            end else begin
              phase_nxt = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          q_push       = 1'b1;
          q_item.data  = in_byte;
          q_item.key   = masked_r ? key_r[key_idx_r] : 8'd0;
          q_item.empty = 1'b0;
          q_item.last  = (remain_r == LenWidth'(1));
          key_idx_nxt  = key_idx_r + 2'd1;
          remain_nxt   = remain_r - LenWidth'(1);
          if (remain_r == LenWidth'(1)) begin
            phase_nxt = PH_HDR0;
          end
        end
        default: phase_nxt = PH_HDR0;
      endcase
      if (len_known) begin
        key_idx_nxt = 2'd0;
        if (masked_nxt) begin
          phase_nxt = PH_MASK;
        end else if (remain_nxt == '0) begin
          q_push    = 1'b1;
          phase_nxt = PH_HDR0;
        end else begin
          phase_nxt = PH_DATA;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HDR0;
      ext_left_r <= 4'd0;
      fin_r      <= 1'b0;
      opcode_r   <= 4'd0;
      masked_r   <= 1'b0;
      remain_r   <= '0;
      key_idx_r  <= 2'd0;
      asm_op_r   <= 4'd0;
    end else begin
      phase_r    <= phase_nxt;
      ext_left_r <= ext_left_nxt;
      fin_r      <= fin_nxt;
      opcode_r   <= opcode_nxt;
      masked_r   <= masked_nxt;
      remain_r   <= remain_nxt;
      key_idx_r  <= key_idx_nxt;
      asm_op_r   <= asm_op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (key_wr) begin
      key_r[key_idx_r] <= in_byte;
    end
  end

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && q_item.empty |-> q_item.last && q_item.data == 8'd0)
    else $error("empty request not marked last");
  a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> q_ready)
    else $error("request pushed into full queue");
  a_data_nonzero_len: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> remain_r != '0)
    else $error("payload phase with no bytes left");

endmodule
`default_nettype wire

@@ rtl/core/wsd_fifo.sv @@
// Short request queue between the header parser and the output stage.
// Depends on wsd_pkg.
`default_nettype none
module wsd_fifo (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                push,
  input  wsd_pkg::wsd_item_t push_item,
  output logic               push_ready,
  input  wire                pop,
  output logic               pop_valid,
  output wsd_pkg::wsd_item_t pop_item
);
  import wsd_pkg::*;

  wsd_item_t          mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CW-1:0] count_r, count_nxt;

  assign push_ready = (count_r != FIFO_CW'(FIFO_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + FIFO_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + FIFO_AW'(1) : rd_ptr_r;
    count_nxt  = count_r + FIFO_CW'(push) - FIFO_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FIFO_CW'(FIFO_DEPTH))
    else $error("queue count overflow");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> pop_valid)
    else $error("pop from empty queue");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || count_r == FIFO_CW'(FIFO_DEPTH)) |-> wr_ptr_r == rd_ptr_r)
    else $error("queue pointers out of step");

endmodule
`default_nettype wire

@@ rtl/core/wsd_back.sv @@
// Output stage: unmasks queued payload requests into the result register.
// Depends on wsd_pkg.
`default_nettype none
module wsd_back (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                q_valid,
  input  wsd_pkg::wsd_item_t q_item,
  output logic               q_pop,
  output logic               out_tvalid,
  input  wire                out_tready,
  output logic [7:0]         out_tdata,
  output logic [11:0]        out_tuser,
  output logic               out_tlast
);
  import wsd_pkg::*;

  logic        valid_r;
  logic [7:0]  data_r;
  logic [11:0] user_r;
  logic        last_r;
  logic        done;

  assign q_pop = q_valid && (!valid_r || out_tready);
  assign done  = q_item.last && q_item.fin && !q_item.is_control;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      data_r <= q_item.data ^ q_item.key;
      user_r <= {done, q_item.empty, q_item.fin, q_item.message_opcode,
                 q_item.is_control, q_item.frame_opcode};
      last_r <= q_item.last;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;
  assign out_tlast  = last_r;

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[11] |-> out_tlast && !out_tuser[4])
    else $error("message done off the last result");
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[10] |-> out_tdata == 8'd0 && out_tlast)
    else $error("empty result carries data");
  a_ctl_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser[4] == (out_tuser[3:0] >= OP_CLS && out_tuser[3:0] <= OP_PONG))
    else $error("control flag does not match opcode");

endmodule
`default_nettype wire

@@ rtl/core/websocket_frame_deframer.sv @@
// Websocket frame deframer: byte stream in, unmasked payload results out.
// Instantiates wsd_front, wsd_fifo and wsd_back; depends on wsd_pkg.
// Takes one received byte per cycle while the queue has room: header, extended
// length and mask key bytes are absorbed by the parser, and each payload
// byte (or one empty result per zero-length frame) enters a four-entry
// queue and leaves through a registered output.
// Input ready drops only when the queue is full under output backpressure.
`default_nettype none
module websocket_frame_deframer #(
  parameter int LENGTH_WIDTH = 64
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [7:0]  out_tdata,  // [7:0] payload_byte
  output logic [11:0] out_tuser,  // [3:0] frame_opcode, [4] is_control,
                                  // [8:5] message_opcode, [9] frame_fin,
                                  // [10] empty_frame, [11] message_done
  output logic        out_tlast   // last_of_frame
);
  import wsd_pkg::*;

  wsd_item_t push_item;
  wsd_item_t pop_item;
  logic      push;
  logic      push_ready;
  logic      pop;
  logic      pop_valid;

  wsd_front #(.LenWidth(LENGTH_WIDTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_byte  (in_tdata),
    .in_ready (in_tready),
    .q_ready  (push_ready),
    .q_push   (push),
    .q_item   (push_item)
  );

  wsd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item)
  );

  wsd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (pop_valid),
    .q_item     (pop_item),
    .q_pop      (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

@@ tb/sv/websocket_frame_deframer_chk.sv @@
// Checker for the websocket frame deframer: watches both streams, predicts
// each payload result from the accepted bytes and compares in order.
// Depends on wsd_pkg for opcode and length codes.
module websocket_frame_deframer_chk #(
  parameter int LENGTH_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,
  input  logic [11:0] out_tuser,
  input  logic        out_tlast,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import wsd_pkg::*;

  localparam int MAX_REPORTS = 100;
  localparam logic [63:0] LEN_MASK = {64{1'b1}} >> (64 - LENGTH_WIDTH);

  typedef enum logic [2:0] {
    P_HDR0,
    P_HDR1,
    P_EXT,
    P_MASK,
    P_DATA
  } parse_phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic [3:0] frame_op;
    logic       ctl;
    logic [3:0] msg_op;
    logic       fin;
    logic       last;
    logic       empty;
    logic       done;
  } payload_result_t;

  parse_phase_e    phase;
  logic [3:0]      ext_left;
  logic            fin_bit;
  logic [3:0]      frame_op;
  logic            masked;
  logic [63:0]     remaining;
  logic [7:0]      key_byte [4];
  logic [1:0]      key_idx;
  logic [3:0]      msg_op;
  payload_result_t pending_payload [$];
  int              reports;

  function automatic payload_result_t make_result(input logic [7:0] data, input logic last,
                                                  input logic empty);
    payload_result_t r;
    r.data     = data;
    r.frame_op = frame_op;
    r.ctl      = (frame_op >= OP_CLS) && (frame_op <= OP_PONG);
    r.msg_op   = msg_op;
    r.fin      = fin_bit;
    r.last     = last;
    r.empty    = empty;
    r.done     = last && fin_bit && !r.ctl;
    return r;
  endfunction

  function automatic logic length_known(output payload_result_t r);
    r = '0;
    key_idx = 2'd0;
    if (masked) begin
      phase = P_MASK;
      return 1'b0;
    end
    if (remaining == 64'd0) begin
      phase = P_HDR0;
      r = make_result(8'h00, 1'b1, 1'b1);
      return 1'b1;
    end
    phase = P_DATA;
    return 1'b0;
  endfunction

  function automatic logic parse_rx_byte(input logic [7:0] b, output payload_result_t r);
    logic [7:0] val;
    r = '0;
    case (phase)
      P_HDR0: begin
        fin_bit  = b[7];
        frame_op = b[3:0];
        if (frame_op == OP_TEXT || frame_op == OP_BIN) msg_op = frame_op;
        phase = P_HDR1;
        return 1'b0;
      end
      P_HDR1: begin
        masked = b[7];
        if (b[6:0] <= LEN7_SHORT_MAX) begin
          remaining = {57'd0, b[6:0]} & LEN_MASK;
          return length_known(r);
        end
        remaining = 64'd0;
        ext_left  = (b[6:0] == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
        phase     = P_EXT;
        return 1'b0;
      end
      P_EXT: begin
        remaining = {remaining[55:0], b} & LEN_MASK;
        ext_left  = ext_left - 4'd1;
        if (ext_left == 4'd0) return length_known(r);
        return 1'b0;
      end
      P_MASK: begin
        key_byte[key_idx] = b;
        key_idx = key_idx + 2'd1;
        if (key_idx != 2'd0) return 1'b0;
        if (remaining == 64'd0) begin
          phase = P_HDR0;
          r = make_result(8'h00, 1'b1, 1'b1);
          return 1'b1;
        end
        phase = P_DATA;
        return 1'b0;
      end
      P_DATA: begin
        val       = masked ? (b ^ key_byte[key_idx]) : b;
        key_idx   = key_idx + 2'd1;
        remaining = (remaining - 64'd1) & LEN_MASK;
        if (remaining == 64'd0) begin
          phase = P_HDR0;
          r = make_result(val, 1'b1, 1'b0);
        end else begin
          r = make_result(val, 1'b0, 1'b0);
        end
        return 1'b1;
      end
      default: begin
        phase = P_HDR0;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [7:0] exp_v,
                                      input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      errors++;
      if (reports < MAX_REPORTS)
        $display("%0t ns: %s expected %0h, got %0h", $time, name, exp_v, act_v);
      reports++;
    end
  endfunction

  always @(posedge clk) begin : watch
    payload_result_t exp_r;
    payload_result_t new_r;
    if (!rst_n) begin
      errors    = 0;
      reports   = 0;
      phase     = P_HDR0;
      ext_left  = 4'd0;
      fin_bit   = 1'b0;
      frame_op  = 4'd0;
      masked    = 1'b0;
      remaining = 64'd0;
      key_idx   = 2'd0;
      msg_op    = 4'd0;
      for (int i = 0; i < 4; i++) key_byte[i] = 8'h00;
      pending_payload.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_payload.size() == 0) begin
          errors++;
          if (reports < MAX_REPORTS)
            $display("%0t ns: result with none expected, got data %0h user %0h last %0b",
                     $time, out_tdata, out_tuser, out_tlast);
          reports++;
        end else begin
          exp_r = pending_payload[0];
          pending_payload.delete(0);
          check_field("payload_byte", exp_r.data, out_tdata);
          check_field("frame_opcode", {4'd0, exp_r.frame_op}, {4'd0, out_tuser[3:0]});
          check_field("is_control", {7'd0, exp_r.ctl}, {7'd0, out_tuser[4]});
          check_field("message_opcode", {4'd0, exp_r.msg_op}, {4'd0, out_tuser[8:5]});
          check_field("frame_fin", {7'd0, exp_r.fin}, {7'd0, out_tuser[9]});
          check_field("empty_frame", {7'd0, exp_r.empty}, {7'd0, out_tuser[10]});
          check_field("message_done", {7'd0, exp_r.done}, {7'd0, out_tuser[11]});
          check_field("last_of_frame", {7'd0, exp_r.last}, {7'd0, out_tlast});
        end
      end
      if (in_tvalid && in_tready) begin
        if (parse_rx_byte(in_tdata, new_r)) pending_payload = {pending_payload, new_r};
      end
    end
    pending = pending_payload.size();
  end

endmodule

@@ tb/sv/websocket_frame_deframer_tb.sv @@
// Testbench top for the websocket frame deframer: clock, reset, frame
// stimulus with random pacing on both streams, watchdog and verdict.
// Depends on wsd_pkg, websocket_frame_deframer and websocket_frame_deframer_chk.
module websocket_frame_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wsd_pkg::*;

  localparam logic [3:0] OP_CONT       = 4'd0;
  localparam logic [3:0] OP_PING       = 4'd9;
  localparam logic [3:0] OP_RSVD_DATA  = 4'd3;
  localparam logic [6:0] LEN7_EXT64    = 7'd127;
  localparam int         N_ITEMS       = 1850;
  localparam int         HOLD_AFTER    = 200;
  localparam int         HOLD_CYCLES   = 300;
  localparam int         IDLE_LIMIT    = 4000;
  localparam int         DRAIN_CYCLES  = 20;

  typedef enum int {
    LEN_SHORT,
    LEN_EXT16,
    LEN_EXT64
  } len_form_e;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic [11:0] out_tuser;
  logic        out_tlast;
  int          errors;
  int          pending;
  int          rx_count;
  int          idle_cycles = 0;
  bit          burst;

  websocket_frame_deframer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  websocket_frame_deframer_chk chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .errors     (errors),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int r;
    int gap;
    gap = 0;
    if (!burst) begin
      r = $urandom_range(0, 99);
      if (r >= 95) begin
        gap = $urandom_range(10, 40);
      end else if (r >= 70) begin
        gap = $urandom_range(1, 3);
      end
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    rx_count++;
  endtask

  task automatic send_frame(input logic fin, input logic [2:0] rsv, input logic [3:0] op,
                            input logic masked, input len_form_e form,
                            input logic [63:0] len, input int n_data);
    send_byte({fin, rsv, op});
    case (form)
      LEN_SHORT: begin
        send_byte({masked, len[6:0]});
      end
      LEN_EXT16: begin
        send_byte({masked, LEN7_EXT16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      default: begin
        send_byte({masked, LEN7_EXT64});
        for (int i = 7; i >= 0; i--) send_byte(len[i*8 +: 8]);
      end
    endcase
    if (masked) begin
      for (int i = 0; i < 4; i++) send_byte(8'($urandom_range(0, 255)));
    end
    for (int i = 0; i < n_data; i++) send_byte(8'($urandom_range(0, 255)));
  endtask

  initial begin : rx_pacing
    int  r;
    int  n;
    bit  held_off;
    held_off   = 1'b0;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!held_off && rx_count >= HOLD_AFTER) begin
        held_off = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      r = $urandom_range(0, 99);
      if (r < 60) begin
        out_tready <= 1'b1;
        n = $urandom_range(1, 20);
      end else if (r < 92) begin
        out_tready <= 1'b0;
        n = $urandom_range(1, 3);
      end else begin
        out_tready <= 1'b0;
        n = $urandom_range(10, 40);
      end
      repeat (n) @(posedge clk);
    end
  end

  initial begin : stimulus
    logic        fin;
    logic [3:0]  op;
    logic [63:0] len;
    len_form_e   form;
    int          r;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 8'h00;
    rx_count  = 0;
    burst     = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send_byte({1'b1, 3'b000, OP_TEXT});
    send_byte({1'b0, 7'd2});
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(1'b0, 3'b000, OP_BIN, 1'b1, LEN_SHORT, 64'd0, 0);
    send_frame(1'b1, 3'b000, OP_PING, 1'b0, LEN_SHORT, 64'd0, 0);
    send_frame(1'b1, 3'b000, OP_CONT, 1'b1, LEN_SHORT, 64'd1, 1);
    send_frame(1'b1, 3'b111, OP_RSVD_DATA, 1'b0, LEN_EXT16, 64'd0, 0);
    send_frame(1'b1, 3'b000, OP_CLS, 1'b0, LEN_EXT64, 64'd1, 1);

    while (rx_count < N_ITEMS) begin
      burst = ($urandom_range(0, 4) == 0);
      fin   = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
        0, 1:    op = OP_CONT;
        2, 3:    op = OP_TEXT;
        4:       op = OP_BIN;
        5:       op = OP_CLS;
        6:       op = OP_PING;
        7:       op = OP_PONG;
        default: op = 4'($urandom_range(0, 15));
      endcase
      r = $urandom_range(0, 99);
      if (r < 60) begin
        form = LEN_SHORT;
        len  = 64'($urandom_range(0, 8));
      end else if (r < 80) begin
        form = LEN_SHORT;
        len  = 64'($urandom_range(9, 40));
      end else if (r < 85) begin
        form = LEN_SHORT;
        len  = 64'(LEN7_SHORT_MAX);
      end else if (r < 93) begin
        form = LEN_EXT16;
        len  = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(256, 296))
                                           : 64'($urandom_range(0, 40));
      end else begin
        form = LEN_EXT64;
        len  = 64'($urandom_range(0, 40));
      end
      send_frame(fin, 3'($urandom_range(0, 7)), op, 1'($urandom_range(0, 1)), form,
                 len, int'(len));
    end

    burst = 1'b0;
    send_frame(1'b1, 3'b000, OP_BIN, 1'b1, LEN_EXT64, 64'h8000_0000_0000_0010, 24);
    in_tvalid <= 1'b0;

    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/wsd_pkg.sv
rtl/core/wsd_front.sv
rtl/core/wsd_fifo.sv
rtl/core/wsd_back.sv
rtl/core/websocket_frame_deframer.sv
tb/sv/websocket_frame_deframer_chk.sv
tb/sv/websocket_frame_deframer_tb.sv
